### src/tsv_pkg.sv
package tsv_pkg;

    localparam int FIELD_W     = 48;
    localparam int STAMP_W     = 48;
    localparam int LIMIT_W     = 15;
    localparam int GAP_W       = 32;
    localparam int CHECK_W     = 5;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int LANES       = 4;

    localparam logic [CHECK_W-1:0] CHECK_ENABLE_RESET = 5'd31;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET        = 15'd32767;
    localparam logic [GAP_W-1:0]   MAX_GAP_RESET      = 32'd1000000;

    localparam int CHK_STATIONARY = 0;
    localparam int CHK_RATE       = 1;
    localparam int CHK_VELOCITY   = 2;
    localparam int CHK_SPIN       = 3;
    localparam int CHK_ACCEL      = 4;

    localparam int LANE_RATE     = 0;
    localparam int LANE_VELOCITY = 1;
    localparam int LANE_SPIN     = 2;
    localparam int LANE_ACCEL    = 3;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_END_MOVING = 3'd1,
        STATUS_RATE       = 3'd2,
        STATUS_VELOCITY   = 3'd3,
        STATUS_SPIN       = 3'd4,
        STATUS_ACCEL      = 3'd5,
        STATUS_BACKWARDS  = 3'd6,
        STATUS_GAP        = 3'd7
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CHECK_ENABLE     = 3'd0,
        REG_RATE_LIMIT       = 3'd1,
        REG_SPEED_LIMIT      = 3'd2,
        REG_SPIN_ACCEL_LIMIT = 3'd3,
        REG_MOVE_ACCEL_LIMIT = 3'd4,
        REG_MAX_GAP          = 3'd5,
        REG_FACE_FORWARD     = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } pipe_ctl_t;

    typedef struct packed {
        logic    valid;
        logic    last;
        logic    moving;
        status_t time_err;
    } s2_info_t;

endpackage

### src/tsv_setpoint_if.sv
interface tsv_setpoint_if;
    import tsv_pkg::*;

    logic               valid;
    logic               ready;
    logic [STAMP_W-1:0] stamp;
    logic [FIELD_W-1:0] rate_vec;
    logic [FIELD_W-1:0] vel_vec;
    logic [FIELD_W-1:0] spin_vec;
    logic [FIELD_W-1:0] move_vec;
    logic               last_point;

    modport source (
        output valid, stamp, rate_vec, vel_vec, spin_vec, move_vec, last_point,
        input  ready
    );

    modport sink (
        input  valid, stamp, rate_vec, vel_vec, spin_vec, move_vec, last_point,
        output ready
    );
endinterface

### src/tsv_status_if.sv
interface tsv_status_if;
    import tsv_pkg::*;

    logic    valid;
    logic    ready;
    status_t status;

    modport source (
        output valid, status,
        input  ready
    );

    modport sink (
        input  valid, status,
        output ready
    );
endinterface

### src/tsv_lane.sv
module tsv_lane #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                        clk,
    input  tsv_pkg::pipe_ctl_t          ctl,
    input  logic [tsv_pkg::FIELD_W-1:0] vec,
    input  logic [tsv_pkg::LIMIT_W-1:0] limit,
    input  logic                        halve,
    output logic                        over
);
    import tsv_pkg::*;

    localparam int CB     = COMPONENT_BITS;
    localparam int EXT_W  = (3 * CB > FIELD_W) ? 3 * CB : FIELD_W;
    localparam int SQ_W   = 2 * CB;
    localparam int NORM_W = 2 * CB + 2;
    localparam int LSQ_W  = 2 * LIMIT_W;
    localparam int CMP_W  = (NORM_W > LSQ_W) ? NORM_W : LSQ_W;

    logic [EXT_W-1:0]  ext;
    logic [CB-1:0]     mag [3];
    logic [SQ_W-1:0]   sq_reg [3];
    logic [LSQ_W-1:0]  limsq_reg;
    logic [NORM_W-1:0] sum;
    logic [NORM_W-1:0] scaled;
    logic              over_reg;
    logic              over_next;

    assign ext = EXT_W'(vec);

    for (genvar k = 0; k < 3; k++) begin : g_comp
        logic [CB-1:0] comp;
        assign comp   = ext[k*CB +: CB];
        assign mag[k] = comp[CB-1] ? (~comp + 1'b1) : comp;

        always_ff @(posedge clk)
        begin
            if (ctl.s1_load)
            begin
                sq_reg[k] <= SQ_W'(mag[k]) * SQ_W'(mag[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        limsq_reg <= LSQ_W'(limit) * LSQ_W'(limit);
    end

    always_comb
    begin
        sum       = NORM_W'(sq_reg[0]) + NORM_W'(sq_reg[1]) + NORM_W'(sq_reg[2]);
        scaled    = halve ? (sum << 2) : sum;
        over_next = CMP_W'(scaled) > CMP_W'(limsq_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s2_load)
        begin
            over_reg <= over_next;
        end
    end

    assign over = over_reg;
endmodule

### src/tsv_merge.sv
module tsv_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsv_pkg::s2_info_t           s2,
    input  logic [tsv_pkg::LANES-1:0]   over,
    input  logic [tsv_pkg::CHECK_W-1:0] check_enable,
    tsv_status_if.source                result,
    output logic                        done
);
    import tsv_pkg::*;

    status_t first_error_reg;
    status_t first_error_next;
    status_t status_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    status_t err;
    status_t resolved;

    assign done = s2.valid && (!s2.last || !out_valid_reg || result.ready);

    always_comb
    begin
        if (s2.time_err != STATUS_OK)
        begin
            err = s2.time_err;
        end
        else if (s2.last)
        begin
            err = (check_enable[CHK_STATIONARY] && s2.moving) ? STATUS_END_MOVING : STATUS_OK;
        end
        else if (check_enable[CHK_RATE] && over[LANE_RATE])
        begin
            err = STATUS_RATE;
        end
        else if (check_enable[CHK_VELOCITY] && over[LANE_VELOCITY])
        begin
            err = STATUS_VELOCITY;
        end
        else if (check_enable[CHK_SPIN] && over[LANE_SPIN])
        begin
            err = STATUS_SPIN;
        end
        else if (check_enable[CHK_ACCEL] && over[LANE_ACCEL])
        begin
            err = STATUS_ACCEL;
        end
        else
        begin
            err = STATUS_OK;
        end
        resolved = (first_error_reg == STATUS_OK) ? err : first_error_reg;
    end

    always_comb
    begin
        first_error_next = first_error_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        if (done)
        begin
            if (s2.last)
            begin
                first_error_next = STATUS_OK;
                out_valid_next   = 1'b1;
            end
            else
            begin
                first_error_next = resolved;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_error_reg <= STATUS_OK;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            first_error_reg <= first_error_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && s2.last)
        begin
            status_reg <= resolved;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.status = status_reg;
endmodule

### src/trajectory_segment_validator_top.sv
// Checks a stream of trajectory setpoints, one per clock while the input is not
// stalled, and returns one status per segment when its last setpoint is taken.
// Four lanes square the components of the rate, velocity, spin and move vectors
// in a first stage and compare the sums of squares with the squared limits in a
// second; a merge stage picks the first error of the segment and registers the
// status when the last setpoint leaves the second stage. The input stalls only
// while a status waits to be taken and both pipeline stages behind it are full.
module trajectory_segment_validator_top #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tsv_setpoint_if.sink                    setpoint,
    tsv_status_if.source                    result,
    input  logic                            cfg_we,
    input  logic [tsv_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tsv_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tsv_pkg::*;

    logic [CHECK_W-1:0] check_enable_reg;
    logic [LIMIT_W-1:0] rate_limit_reg;
    logic [LIMIT_W-1:0] speed_limit_reg;
    logic [LIMIT_W-1:0] spin_accel_limit_reg;
    logic [LIMIT_W-1:0] move_accel_limit_reg;
    logic [GAP_W-1:0]   max_gap_reg;
    logic               face_forward_reg;

    logic [STAMP_W-1:0] prev_stamp_reg;
    logic               have_prev_reg;

    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic               s1_moving_reg;
    status_t            s1_time_err_reg;
    logic               s2_valid_reg;
    logic               s2_last_reg;
    logic               s2_moving_reg;
    status_t            s2_time_err_reg;

    pipe_ctl_t          ctl;
    s2_info_t           s2;
    logic               done;
    logic               in_acc;
    status_t            time_err;
    logic               moving;
    logic [STAMP_W-1:0] gap;
    logic [LANES-1:0]   over;
    logic [FIELD_W-1:0] lane_vec [LANES];
    logic [LIMIT_W-1:0] lane_limit [LANES];
    logic               lane_halve [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_enable_reg     <= CHECK_ENABLE_RESET;
            rate_limit_reg       <= LIMIT_RESET;
            speed_limit_reg      <= LIMIT_RESET;
            spin_accel_limit_reg <= LIMIT_RESET;
            move_accel_limit_reg <= LIMIT_RESET;
            max_gap_reg          <= MAX_GAP_RESET;
            face_forward_reg     <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_CHECK_ENABLE:     check_enable_reg     <= cfg_data[CHECK_W-1:0];
                REG_RATE_LIMIT:       rate_limit_reg       <= cfg_data[LIMIT_W-1:0];
                REG_SPEED_LIMIT:      speed_limit_reg      <= cfg_data[LIMIT_W-1:0];
                REG_SPIN_ACCEL_LIMIT: spin_accel_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_MOVE_ACCEL_LIMIT: move_accel_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_MAX_GAP:          max_gap_reg          <= cfg_data[GAP_W-1:0];
                REG_FACE_FORWARD:     face_forward_reg     <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    assign ctl.s2_load     = !s2_valid_reg || done;
    assign ctl.s1_load     = !s1_valid_reg || ctl.s2_load;
    assign setpoint.ready  = ctl.s1_load;
    assign in_acc          = setpoint.valid && ctl.s1_load;

    always_comb
    begin
        gap    = setpoint.stamp - prev_stamp_reg;
        moving = (setpoint.rate_vec != '0) || (setpoint.vel_vec != '0)
              || (setpoint.spin_vec != '0) || (setpoint.move_vec != '0);
        if (!have_prev_reg)
        begin
            time_err = STATUS_OK;
        end
        else if (setpoint.stamp < prev_stamp_reg)
        begin
            time_err = STATUS_BACKWARDS;
        end
        else if (gap > STAMP_W'(max_gap_reg))
        begin
            time_err = STATUS_GAP;
        end
        else
        begin
            time_err = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_stamp_reg <= '0;
            have_prev_reg  <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                prev_stamp_reg <= setpoint.last_point ? '0 : setpoint.stamp;
                have_prev_reg  <= !setpoint.last_point;
            end
            if (ctl.s1_load)
            begin
                s1_valid_reg <= setpoint.valid;
            end
            if (ctl.s2_load)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.s1_load)
        begin
            s1_last_reg     <= setpoint.last_point;
            s1_moving_reg   <= moving;
            s1_time_err_reg <= time_err;
        end
        if (ctl.s2_load)
        begin
            s2_last_reg     <= s1_last_reg;
            s2_moving_reg   <= s1_moving_reg;
            s2_time_err_reg <= s1_time_err_reg;
        end
    end

    assign lane_vec[LANE_RATE]       = setpoint.rate_vec;
    assign lane_vec[LANE_VELOCITY]   = setpoint.vel_vec;
    assign lane_vec[LANE_SPIN]       = setpoint.spin_vec;
    assign lane_vec[LANE_ACCEL]      = setpoint.move_vec;
    assign lane_limit[LANE_RATE]     = rate_limit_reg;
    assign lane_limit[LANE_VELOCITY] = speed_limit_reg;
    assign lane_limit[LANE_SPIN]     = spin_accel_limit_reg;
    assign lane_limit[LANE_ACCEL]    = move_accel_limit_reg;
    assign lane_halve[LANE_RATE]     = 1'b0;
    assign lane_halve[LANE_VELOCITY] = 1'b0;
    assign lane_halve[LANE_SPIN]     = !face_forward_reg;
    assign lane_halve[LANE_ACCEL]    = !face_forward_reg;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        tsv_lane #(
            .COMPONENT_BITS (COMPONENT_BITS)
        ) u_lane (
            .clk   (clk),
            .ctl   (ctl),
            .vec   (lane_vec[i]),
            .limit (lane_limit[i]),
            .halve (lane_halve[i]),
            .over  (over[i])
        );
    end

    assign s2.valid    = s2_valid_reg;
    assign s2.last     = s2_last_reg;
    assign s2.moving   = s2_moving_reg;
    assign s2.time_err = s2_time_err_reg;

    tsv_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .s2           (s2),
        .over         (over),
        .check_enable (check_enable_reg),
        .result       (result),
        .done         (done)
    );
endmodule

### src/tsv_checker.sv
module tsv_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready
);
    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg + 2'((in_valid && in_ready && in_last) ? 1 : 0)
                     - 2'((out_valid && out_ready) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_stall_only_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without a waiting status");

    a_status_has_segment: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != 2'd0))
        else $error("status offered with no segment end taken");

    a_status_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("status dropped before transaction");
endmodule

bind trajectory_segment_validator_top tsv_checker u_tsv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (setpoint.valid),
    .in_ready  (setpoint.ready),
    .in_last   (setpoint.last_point),
    .out_valid (result.valid),
    .out_ready (result.ready)
);
